// File: rtl/core/mcfe_pkg.sv
// Shared types, register codes, sequencing steps and constants of the current-sensing front end.
`timescale 1ns / 1ps

package mcfe_pkg;

  localparam int SAMPLE_W = 12;
  localparam int WORD_W   = 32;
  localparam int STEP_W   = 4;
  localparam int FLAGS_W  = 5;

  localparam logic signed [31:0] Q24_ONE        = 32'sd16777216;
  localparam logic signed [31:0] Q24_TWO        = 32'sd33554432;
  localparam logic signed [31:0] INV_SQRT3      = 32'sd9686330;
  localparam logic signed [31:0] CENTRE_OFFSET  = 32'sd8388607;
  localparam logic signed [12:0] ADC_MID        = 13'sd2048;

  localparam logic [STEP_W-1:0] STEP_MUL_GAIN  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_MUL_MEAN  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_MUL_REST  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_MUL_TWICE = 4'd3;
  localparam logic [STEP_W-1:0] STEP_DIFF      = 4'd4;
  localparam logic [STEP_W-1:0] STEP_MUL_BETA  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_BETA      = 4'd6;
  localparam logic [STEP_W-1:0] STEP_FLAGS     = 4'd7;
  localparam logic [STEP_W-1:0] STEP_LAST      = 4'd8;

  localparam int FLAG_ALPHA = 0;
  localparam int FLAG_BETA  = 1;
  localparam int FLAG_DIFF  = 2;
  localparam int FLAG_OVER  = 3;
  localparam int FLAG_UNDER = 4;

  typedef enum logic [7:0] {
    REG_GAIN_U      = 8'd0,
    REG_GAIN_V      = 8'd1,
    REG_GAIN_W      = 8'd2,
    REG_SMOOTHING   = 8'd3,
    REG_UDC_OFFSET  = 8'd4,
    REG_UDC_GAIN    = 8'd5,
    REG_TEMP_OFFSET = 8'd6,
    REG_TEMP_GAIN   = 8'd7
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_u;
    logic [SAMPLE_W-1:0] sample_v;
    logic [SAMPLE_W-1:0] sample_w;
    logic [SAMPLE_W-1:0] sample_udc;
    logic [SAMPLE_W-1:0] sample_temp;
    logic signed [WORD_W-1:0] current_limit;
    logic signed [WORD_W-1:0] udc_upper;
    logic signed [WORD_W-1:0] udc_lower;
  } sample_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] alpha_current;
    logic signed [WORD_W-1:0] beta_current;
    logic signed [WORD_W-1:0] dc_voltage;
    logic signed [WORD_W-1:0] temperature;
    logic [FLAGS_W-1:0]       warn_flags;
    logic signed [WORD_W-1:0] mean_u_out;
    logic signed [WORD_W-1:0] mean_v_out;
    logic signed [WORD_W-1:0] mean_w_out;
  } result_t;

  typedef struct packed {
    logic [7:0]        index;
    logic [WORD_W-1:0] value;
  } cfg_beat_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] gain_u;
    logic signed [WORD_W-1:0] gain_v;
    logic signed [WORD_W-1:0] gain_w;
    logic [24:0]              smoothing_factor;
    logic signed [11:0]       udc_offset;
    logic signed [WORD_W-1:0] udc_gain;
    logic signed [11:0]       temp_offset;
    logic signed [WORD_W-1:0] temp_gain;
  } cfg_regs_t;

  typedef struct packed {
    logic              active;
    logic [STEP_W-1:0] step;
  } lane_ctrl_t;

endpackage

// File: rtl/core/mcfe_stream_if.sv
// Valid/ready channel interface carrying one payload per beat.
`timescale 1ns / 1ps

interface mcfe_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/mcfe_phase_lane.sv
// Phase current lane: centring, gain, running mean and doubled-current difference.
`timescale 1ns / 1ps

module mcfe_phase_lane (
  input  logic                   clk,
  input  logic                   rst,
  input  mcfe_pkg::lane_ctrl_t   ctrl,
  input  logic [11:0]            sample,
  input  logic signed [31:0]     gain,
  input  logic [24:0]            k,
  output logic signed [31:0]     mean,
  output logic signed [31:0]     diff
);

  logic signed [24:0] centred_raw;
  logic signed [31:0] centred;
  logic signed [25:0] one_minus_k;
  logic signed [26:0] twice;
  logic signed [31:0] op_a;
  logic signed [31:0] op_b;
  logic signed [63:0] prod;
  logic signed [31:0] prod_q24;
  logic signed [31:0] cu;
  logic signed [31:0] mean_part;

  assign centred_raw = $signed({1'b0, sample, 12'b0}) - 25'(mcfe_pkg::CENTRE_OFFSET);
  assign centred     = {{2{centred_raw[24]}}, centred_raw, 5'b0};
  assign one_minus_k = 26'(mcfe_pkg::Q24_ONE) - $signed({1'b0, k});
  assign twice       = 27'(mcfe_pkg::Q24_TWO) - $signed({2'b0, k});
  assign prod_q24    = prod[55:24];

  always_comb begin
    case (ctrl.step)
      mcfe_pkg::STEP_MUL_GAIN: begin
        op_a = centred;
        op_b = gain;
      end
      mcfe_pkg::STEP_MUL_MEAN: begin
        op_a = mean;
        op_b = $signed({7'b0, k});
      end
      mcfe_pkg::STEP_MUL_REST: begin
        op_a = cu;
        op_b = {{6{one_minus_k[25]}}, one_minus_k};
      end
      mcfe_pkg::STEP_MUL_TWICE: begin
        op_a = cu;
        op_b = {{5{twice[26]}}, twice};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.active) begin
      prod <= 64'(op_a) * 64'(op_b);
      if (ctrl.step == mcfe_pkg::STEP_MUL_MEAN) begin
        cu <= prod_q24;
      end
      if (ctrl.step == mcfe_pkg::STEP_MUL_REST) begin
        mean_part <= prod_q24;
      end
      if (ctrl.step == mcfe_pkg::STEP_DIFF) begin
        diff <= prod_q24 - mean;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mean <= '0;
    end else if (ctrl.active && ctrl.step == mcfe_pkg::STEP_MUL_TWICE) begin
      mean <= mean_part + prod_q24;
    end
  end

endmodule

// File: rtl/core/mcfe_scale_lane.sv
// Scalar lane: centres a 12-bit sample, removes an offset and applies a Q8 gain.
`timescale 1ns / 1ps

module mcfe_scale_lane (
  input  logic                 clk,
  input  mcfe_pkg::lane_ctrl_t ctrl,
  input  logic [11:0]          sample,
  input  logic signed [11:0]   offset,
  input  logic signed [31:0]   gain,
  output logic signed [31:0]   value
);

  logic signed [12:0] centred;
  logic signed [63:0] prod;

  assign centred = $signed({1'b0, sample}) - mcfe_pkg::ADC_MID - $signed({offset[11], offset});

  always_ff @(posedge clk) begin
    if (ctrl.active) begin
      if (ctrl.step == mcfe_pkg::STEP_MUL_GAIN) begin
        prod <= 64'(centred) * 64'(gain);
      end
      if (ctrl.step == mcfe_pkg::STEP_MUL_MEAN) begin
        value <= prod[39:8];
      end
    end
  end

endmodule

// File: rtl/core/mcfe_merge.sv
// Merging stage: beta component of the Clarke transform and the warning flags.
`timescale 1ns / 1ps

module mcfe_merge (
  input  logic                 clk,
  input  mcfe_pkg::lane_ctrl_t ctrl,
  input  logic signed [31:0]   alpha,
  input  logic signed [31:0]   tv,
  input  logic signed [31:0]   udc,
  input  logic signed [31:0]   limit,
  input  logic signed [31:0]   upper,
  input  logic signed [31:0]   lower,
  output logic signed [31:0]   beta,
  output logic [4:0]           flags
);

  function automatic logic signed [32:0] magnitude(input logic signed [31:0] x);
    logic signed [32:0] wide;
    wide = {x[31], x};
    return x[31] ? -wide : wide;
  endfunction

  logic signed [31:0] beta_in;
  logic signed [31:0] alpha_minus_beta;
  logic signed [32:0] limit_wide;
  logic signed [63:0] prod;
  logic [4:0]         flags_next;

  assign beta_in          = alpha + {tv[30:0], 1'b0};
  assign alpha_minus_beta = alpha - beta;
  assign limit_wide       = {limit[31], limit};

  always_comb begin
    flags_next = '0;
    flags_next[mcfe_pkg::FLAG_ALPHA] = magnitude(alpha) >= limit_wide;
    flags_next[mcfe_pkg::FLAG_BETA]  = magnitude(beta) >= limit_wide;
    flags_next[mcfe_pkg::FLAG_DIFF]  = magnitude(alpha_minus_beta) >= limit_wide;
    flags_next[mcfe_pkg::FLAG_OVER]  = udc > upper;
    flags_next[mcfe_pkg::FLAG_UNDER] = udc < lower;
  end

  always_ff @(posedge clk) begin
    if (ctrl.active) begin
      if (ctrl.step == mcfe_pkg::STEP_MUL_BETA) begin
        prod <= 64'(beta_in) * 64'(mcfe_pkg::INV_SQRT3);
      end
      if (ctrl.step == mcfe_pkg::STEP_BETA) begin
        beta <= prod[55:24];
      end
      if (ctrl.step == mcfe_pkg::STEP_FLAGS) begin
        flags <= flags_next;
      end
    end
  end

endmodule

// File: rtl/core/motor_adc_clarke_front_end_top.sv
// Top level of the three-phase current-sensing front end with Clarke transform.
`timescale 1ns / 1ps

// Usage:
// samples carries one ADC conversion set per beat (three phase currents, DC-link
// voltage, temperature and the limits for this set); results carries one beat per set
// with alpha, beta, scaled voltage and temperature, warning flags and the updated means.
// cfg writes the gain, smoothing and offset registers; it is always ready and is
// meant to be written only while no set is in flight.
// A set is taken only while the block is idle. Five lanes (three phase currents,
// voltage, temperature) each own one multiplier; the phase lanes run four dependent
// multiplies in sequence and the merge stage adds one more for beta, so a set is
// worked through all its steps before the next set can be accepted.
// The result sits in an output register, so the next set is taken and worked on
// while the previous result waits. If the receiver still stalls when the next result
// is finished, the block holds that result and takes no new set until it moves.
// Synchronous reset loads the register defaults, clears the running means and
// empties the output register.
module motor_adc_clarke_front_end_top (
  input  logic           clk,
  input  logic           rst,
  mcfe_stream_if.sink    samples,
  mcfe_stream_if.source  results,
  mcfe_stream_if.sink    cfg
);

  mcfe_pkg::state_t            state;
  mcfe_pkg::state_t            state_next;
  logic [mcfe_pkg::STEP_W-1:0] step;
  mcfe_pkg::sample_t           in_reg;
  mcfe_pkg::cfg_regs_t         regs;
  mcfe_pkg::cfg_beat_t         cfg_beat;
  mcfe_pkg::lane_ctrl_t        ctrl;
  mcfe_pkg::result_t           out_data;
  logic                        out_valid;
  logic                        in_ready;
  logic                        load;
  logic                        accept;
  logic                        finished;

  logic signed [31:0] mean_u;
  logic signed [31:0] mean_v;
  logic signed [31:0] mean_w;
  logic signed [31:0] diff_u;
  logic signed [31:0] diff_v;
  logic signed [31:0] udc;
  logic signed [31:0] temp;
  logic signed [31:0] beta;
  logic [4:0]         flags;

  assign cfg_beat      = cfg.data;
  assign cfg.ready     = 1'b1;
  assign samples.ready = in_ready;
  assign results.valid = out_valid;
  assign results.data  = out_data;
  assign accept        = samples.valid && in_ready;
  assign finished      = (state == mcfe_pkg::ST_RUN) && (step == mcfe_pkg::STEP_LAST);

  always_comb begin
    state_next = state;
    case (state)
      mcfe_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = mcfe_pkg::ST_RUN;
        end
      end
      mcfe_pkg::ST_RUN: begin
        if (finished) begin
          state_next = load ? mcfe_pkg::ST_IDLE : mcfe_pkg::ST_HOLD;
        end
      end
      mcfe_pkg::ST_HOLD: begin
        if (load) begin
          state_next = mcfe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mcfe_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = (state == mcfe_pkg::ST_IDLE);
    load        = (finished || state == mcfe_pkg::ST_HOLD) && (!out_valid || results.ready);
    ctrl.active = (state == mcfe_pkg::ST_RUN);
    ctrl.step   = step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcfe_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        step <= '0;
      end else if (state == mcfe_pkg::ST_RUN && step != mcfe_pkg::STEP_LAST) begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_reg <= samples.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.alpha_current <= diff_u;
      out_data.beta_current  <= beta;
      out_data.dc_voltage    <= udc;
      out_data.temperature   <= temp;
      out_data.warn_flags    <= flags;
      out_data.mean_u_out    <= mean_u;
      out_data.mean_v_out    <= mean_v;
      out_data.mean_w_out    <= mean_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.gain_u           <= mcfe_pkg::Q24_ONE;
      regs.gain_v           <= mcfe_pkg::Q24_ONE;
      regs.gain_w           <= mcfe_pkg::Q24_ONE;
      regs.smoothing_factor <= '0;
      regs.udc_offset       <= '0;
      regs.udc_gain         <= 32'sd256;
      regs.temp_offset      <= '0;
      regs.temp_gain        <= 32'sd256;
    end else if (cfg.valid) begin
      case (cfg_beat.index)
        mcfe_pkg::REG_GAIN_U:      regs.gain_u           <= cfg_beat.value;
        mcfe_pkg::REG_GAIN_V:      regs.gain_v           <= cfg_beat.value;
        mcfe_pkg::REG_GAIN_W:      regs.gain_w           <= cfg_beat.value;
        mcfe_pkg::REG_SMOOTHING:   regs.smoothing_factor <= cfg_beat.value[24:0];
        mcfe_pkg::REG_UDC_OFFSET:  regs.udc_offset       <= cfg_beat.value[11:0];
        mcfe_pkg::REG_UDC_GAIN:    regs.udc_gain         <= cfg_beat.value;
        mcfe_pkg::REG_TEMP_OFFSET: regs.temp_offset      <= cfg_beat.value[11:0];
        mcfe_pkg::REG_TEMP_GAIN:   regs.temp_gain        <= cfg_beat.value;
        default: begin
        end
      endcase
    end
  end

  mcfe_phase_lane u_lane_u (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .sample (in_reg.sample_u),
    .gain   (regs.gain_u),
    .k      (regs.smoothing_factor),
    .mean   (mean_u),
    .diff   (diff_u)
  );

  mcfe_phase_lane u_lane_v (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .sample (in_reg.sample_v),
    .gain   (regs.gain_v),
    .k      (regs.smoothing_factor),
    .mean   (mean_v),
    .diff   (diff_v)
  );

  mcfe_phase_lane u_lane_w (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .sample (in_reg.sample_w),
    .gain   (regs.gain_w),
    .k      (regs.smoothing_factor),
    .mean   (mean_w),
    .diff   ()
  );

  mcfe_scale_lane u_lane_udc (
    .clk    (clk),
    .ctrl   (ctrl),
    .sample (in_reg.sample_udc),
    .offset (regs.udc_offset),
    .gain   (regs.udc_gain),
    .value  (udc)
  );

  mcfe_scale_lane u_lane_temp (
    .clk    (clk),
    .ctrl   (ctrl),
    .sample (in_reg.sample_temp),
    .offset (regs.temp_offset),
    .gain   (regs.temp_gain),
    .value  (temp)
  );

  mcfe_merge u_merge (
    .clk   (clk),
    .ctrl  (ctrl),
    .alpha (diff_u),
    .tv    (diff_v),
    .udc   (udc),
    .limit (in_reg.current_limit),
    .upper (in_reg.udc_upper),
    .lower (in_reg.udc_lower),
    .beta  (beta),
    .flags (flags)
  );

endmodule
